>>> sv/cdc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar date counter package
// Shared date types, operation codes, sequencer states and the Gregorian
// month-length helpers used by the day-step unit and the top level.
// ----------------------------------------------------------------------------
package cdc_pkg;

  // Default parameter values.
  localparam int MAX_YEAR_DEF    = 9999;
  localparam int COUNT_WIDTH_DEF = 16;

  // Field widths of the date, the operation code and the count port.
  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int FUNC_W  = 3;
  localparam int CNT_PORT_W = 16;

  // Lowest date that is kept.
  localparam logic [YEAR_W-1:0] FLOOR_YEAR = YEAR_W'(1900);

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_LOAD = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_NEXT = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_PREV = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_ADD  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_SUB  = 3'd4;

  // Multiplicative inverse of 25 modulo 4096, and the largest product that
  // a multiple of 25 can give under that inverse.
  localparam logic [11:0] INV25     = 12'd3113;
  localparam logic [11:0] DIV25_LIM = 12'd163;

  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
  } date_t;

  typedef struct packed {
    date_t date;
    logic  blocked;
  } step_res_t;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Gregorian leap-year rule. A year divisible by 100 is a multiple of 4
  // whose quarter is a multiple of 25; a year divisible by 400 is then also
  // a multiple of 16. Divisibility by 25 uses the modular inverse test.
  function automatic logic is_leap(input logic [YEAR_W-1:0] year);
    logic [23:0] prod;
    logic        div25;
    prod  = {12'd0, year[13:2]} * {12'd0, INV25};
    div25 = (prod[11:0] <= DIV25_LIM);
    return (year[1:0] == 2'd0) && (!div25 || (year[3:2] == 2'd0));
  endfunction

  // Number of days in a month, given the leap flag of its year.
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (month) inside
      4'd2:                    len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      default:                 len = 5'd31;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

>>> sv/cdc_step_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar day-step unit
// Moves a date one day forward or back, blocking at the first day of 1900
// and at the last day of the maximum year. Shared by every step operation.
// ----------------------------------------------------------------------------
module cdc_step_unit #(
  parameter int MAX_YEAR = cdc_pkg::MAX_YEAR_DEF
) (
  input  wire cdc_pkg::date_t     cur,
  input  wire                     down,
  output cdc_pkg::step_res_t      res
);
  import cdc_pkg::*;

  logic             leap;
  logic [DAY_W-1:0] len_cur;
  logic [DAY_W-1:0] len_prev;
  logic             at_ceiling;
  logic             at_floor;

  // Month lengths of this month and of the previous one in the same year.
  assign leap       = is_leap(cur.year);
  assign len_cur    = month_len(cur.month, leap);
  assign len_prev   = month_len(cur.month - MONTH_W'(1), leap);
  assign at_ceiling = (cur.year >= YEAR_W'(MAX_YEAR)) && (cur.month == MONTH_W'(12)) &&
                      (cur.day == DAY_W'(31));
  assign at_floor   = (cur.year <= FLOOR_YEAR) && (cur.month == MONTH_W'(1)) &&
                      (cur.day == DAY_W'(1));

  // Next or previous day, or the same date when a bound blocks the step.
  always_comb begin
    res.date    = cur;
    res.blocked = 1'b0;
    if (down) begin
      if (at_floor) begin
        res.blocked = 1'b1;
      end else if (cur.day > DAY_W'(1)) begin
        res.date.day = cur.day - DAY_W'(1);
      end else if (cur.month <= MONTH_W'(1)) begin
        res.date.month = MONTH_W'(12);
        res.date.year  = cur.year - YEAR_W'(1);
        res.date.day   = DAY_W'(31);
      end else begin
        res.date.month = cur.month - MONTH_W'(1);
        res.date.day   = len_prev;
      end
    end else begin
      if (at_ceiling) begin
        res.blocked = 1'b1;
      end else if (cur.day < len_cur) begin
        res.date.day = cur.day + DAY_W'(1);
      end else begin
        res.date.day = DAY_W'(1);
        if (cur.month >= MONTH_W'(12)) begin
          res.date.month = MONTH_W'(1);
          res.date.year  = cur.year + YEAR_W'(1);
        end else begin
          res.date.month = cur.month + MONTH_W'(1);
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> sv/calendar_date_counter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Calendar date counter
// Holds a Gregorian date and loads, steps or counts it by days under a
// small sequencer that reuses one day-step unit.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid / in_stall) carries one operation per
// transaction: load a date, step one day forward or back, or add or subtract
// day_count days. The output channel (out_valid / out_stall) returns exactly
// one result per operation: the date afterwards with the accepted and
// clamped flags.
// A load, a single step, a zero count or an unused code gives its result in
// the cycle after the transaction. A count of n days first takes the
// transaction and then runs the day-step unit once per cycle, n times in all,
// ending early when a date bound is reached; its result is registered after
// the last step. The next transaction is taken in the cycle the result is taken,
// or at once if the output register is empty.
// While the receiver stalls, the result and date hold and in_stall stays
// high. Reset sets the date to 1 January 1900 and empties the output.
// ----------------------------------------------------------------------------
module calendar_date_counter #(
  parameter int MAX_YEAR    = cdc_pkg::MAX_YEAR_DEF,
  parameter int COUNT_WIDTH = cdc_pkg::COUNT_WIDTH_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire  [cdc_pkg::FUNC_W-1:0]       func,
  input  wire  [cdc_pkg::DAY_W-1:0]        day_in,
  input  wire  [cdc_pkg::MONTH_W-1:0]      month_in,
  input  wire  [cdc_pkg::YEAR_W-1:0]       year_in,
  input  wire  [cdc_pkg::CNT_PORT_W-1:0]   day_count,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic [cdc_pkg::DAY_W-1:0]        day_out,
  output logic [cdc_pkg::MONTH_W-1:0]      month_out,
  output logic [cdc_pkg::YEAR_W-1:0]       year_out,
  output logic                             accepted,
  output logic                             clamped
);
  import cdc_pkg::*;

  localparam int CNT_W = (COUNT_WIDTH < CNT_PORT_W) ? COUNT_WIDTH : CNT_PORT_W;

  state_t           state, state_next;
  date_t            date, date_next;
  logic [CNT_W-1:0] remaining, remaining_next;
  logic             dir_down, dir_down_next;
  logic             out_valid_next;
  logic             accepted_next;
  logic             clamped_next;

  logic             in_take;
  logic             step_down;
  step_res_t        step;
  logic [CNT_W-1:0] count;
  logic             load_ok;

  // New transactions only when idle and the result register is free.
  assign in_stall = (state != ST_IDLE) || (out_valid && out_stall);
  assign in_take  = in_valid && !in_stall;
  assign count    = day_count[CNT_W-1:0];

  // Load check against the month length of the loaded year.
  assign load_ok = (month_in >= MONTH_W'(1)) && (month_in <= MONTH_W'(12)) &&
                   (year_in >= FLOOR_YEAR) && (year_in <= YEAR_W'(MAX_YEAR)) &&
                   (day_in >= DAY_W'(1)) &&
                   (day_in <= month_len(month_in, is_leap(year_in)));

  // The shared day-step unit works on the held date.
  assign step_down = (state == ST_RUN) ? dir_down :
                     ((func == FUNC_PREV) || (func == FUNC_SUB));

  cdc_step_unit #(
    .MAX_YEAR (MAX_YEAR)
  ) u_step (
    .cur  (date),
    .down (step_down),
    .res  (step)
  );

  // Sequencer: decode a new transaction or run one day of a count.
  always_comb begin
    state_next     = state;
    date_next      = date;
    remaining_next = remaining;
    dir_down_next  = dir_down;
    out_valid_next = out_valid && out_stall;
    accepted_next  = accepted;
    clamped_next   = clamped;
    unique case (state)
      ST_IDLE: begin
        if (in_take) begin
          unique case (func)
            FUNC_LOAD: begin
              if (load_ok) begin
                date_next.day   = day_in;
                date_next.month = month_in;
                date_next.year  = year_in;
              end
              accepted_next  = load_ok;
              clamped_next   = 1'b0;
              out_valid_next = 1'b1;
            end
            FUNC_NEXT, FUNC_PREV: begin
              date_next      = step.date;
              accepted_next  = 1'b1;
              clamped_next   = step.blocked;
              out_valid_next = 1'b1;
            end
            FUNC_ADD, FUNC_SUB: begin
              if (count == '0) begin
                accepted_next  = 1'b1;
                clamped_next   = 1'b0;
                out_valid_next = 1'b1;
              end else begin
                remaining_next = count;
                dir_down_next  = (func == FUNC_SUB);
                state_next     = ST_RUN;
              end
            end
            default: begin
              accepted_next  = 1'b0;
              clamped_next   = 1'b0;
              out_valid_next = 1'b1;
            end
          endcase
        end
      end
      ST_RUN: begin
        date_next = step.date;
        if (step.blocked || (remaining == CNT_W'(1))) begin
          accepted_next  = 1'b1;
          clamped_next   = step.blocked;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end else begin
          remaining_next = remaining - CNT_W'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control and date registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      out_valid  <= 1'b0;
      date.day   <= DAY_W'(1);
      date.month <= MONTH_W'(1);
      date.year  <= FLOOR_YEAR;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      date      <= date_next;
    end
  end

  // Count, direction and result flags.
  always_ff @(posedge clk) begin
    remaining <= remaining_next;
    dir_down  <= dir_down_next;
    accepted  <= accepted_next;
    clamped   <= clamped_next;
  end

  // The held date is the result date.
  assign day_out   = date.day;
  assign month_out = date.month;
  assign year_out  = date.year;

  // A count never runs with a result still waiting.
  a_run_no_result: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> !out_valid)
    else $error("count running while a result is pending");

  // The date always stays a legal calendar date within the bounds.
  a_date_range: assert property (@(posedge clk) disable iff (rst)
    (date.month >= MONTH_W'(1)) && (date.month <= MONTH_W'(12)) &&
    (date.year >= FLOOR_YEAR) && (date.year <= YEAR_W'(MAX_YEAR)) &&
    (date.day >= DAY_W'(1)) &&
    (date.day <= month_len(date.month, is_leap(date.year))))
    else $error("date out of range");

  // A clamped result always belongs to an accepted step.
  a_clamp_accepted: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clamped) |-> accepted)
    else $error("clamped flag without accepted");

  // The date does not move while a result waits on the receiver.
  a_date_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(date))
    else $error("date changed while result stalled");

  // Remaining count never reaches zero inside a run.
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> (remaining != '0))
    else $error("count run with zero days left");

endmodule
`default_nettype wire
